// ===== hw/rtl/rle8_pkg.sv =====
`default_nettype none
package rle8_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int MAX_ROWS      = 1024;

    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 13;
    localparam int ROWS_W   = 11;
    localparam int ADDR_W   = 22;
    localparam int COUNT_W  = 13;
    localparam int POS_W    = 23;
    localparam int COL_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    localparam int OUT_FIELDS_W = ADDR_W + COUNT_W + BYTE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd1;

    // Image geometry derived from the configuration registers
    typedef struct packed {
        logic [WIDTH_W-1:0] stride;
        logic [POS_W-1:0]   img_end;
    } t_geom;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  value;
        logic               done;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/bmp_rle8_decoder.sv =====
`default_nettype none
// An accepted byte sits in the input register; its write command is registered in the queue.
// One byte per cycle unless the queue is full; parse and position update are combinational.
// Results sit in a two-entry output queue; input stalls only when that queue is full.
// Reset (synchronous, active low): parser idle, position and column zero, queue empty,
// width and row count both 1 (stride 4, image end 4).
module bmp_rle8_decoder (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [7:0]                           i_s_tdata,  // [7:0] data_byte
    input  wire logic                                 i_s_tuser,  // [0] start_image
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // [21:0] write_addr, [34:22] fill_count, [42:35] fill_value, rest zero
    output logic [rle8_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    output logic                                      o_m_tlast,  // image_done
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [rle8_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rle8_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rle8_pkg::*;

    logic [WIDTH_W-1:0] r_stride, n_stride;
    logic [ROWS_W-1:0]  r_rows, n_rows;
    logic [POS_W-1:0]   r_img_end;
    logic [WIDTH_W-1:0] w_clamp;
    logic [ROWS_W-1:0]  h_clamp;
    logic [WIDTH_W+ROWS_W-1:0] end_prod;
    t_geom              geom;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               fire;

    logic               res_valid;
    t_result            res;
    t_result            r_q0, r_q1;
    logic [1:0]         r_q_cnt;
    logic               push, pop;

    // configuration: clamp and precompute stride and image end
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_clamp = i_cfg_data[WIDTH_W-1:0];
        if (w_clamp == '0) begin
            w_clamp = WIDTH_W'(1);
        end else if (w_clamp > WIDTH_W'(MAX_ROW_BYTES)) begin
            w_clamp = WIDTH_W'(MAX_ROW_BYTES);
        end
        h_clamp = i_cfg_data[ROWS_W-1:0];
        if (h_clamp == '0) begin
            h_clamp = ROWS_W'(1);
        end else if (h_clamp > ROWS_W'(MAX_ROWS)) begin
            h_clamp = ROWS_W'(MAX_ROWS);
        end
        n_stride = r_stride;
        n_rows   = r_rows;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH_PIXELS: n_stride = (w_clamp + WIDTH_W'(3)) & ~WIDTH_W'(3);
                REG_ROW_COUNT:    n_rows   = h_clamp;
                default:          n_stride = r_stride;
            endcase
        end
        end_prod = (WIDTH_W+ROWS_W)'(n_stride) * (WIDTH_W+ROWS_W)'(n_rows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride  <= WIDTH_W'(4);
            r_rows    <= ROWS_W'(1);
            r_img_end <= POS_W'(4);
        end else if (i_cfg_valid) begin
            r_stride  <= n_stride;
            r_rows    <= n_rows;
            r_img_end <= end_prod[POS_W-1:0];
        end
    end

    assign geom.stride  = r_stride;
    assign geom.img_end = r_img_end;

    // input register; process whenever the output queue has a free slot
    assign fire       = r_in_valid && (r_q_cnt != 2'd2);
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    rle8_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_geom      (geom),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // two-entry result queue
    assign push = fire && res_valid;
    assign pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (push && r_q_cnt == 2'd1) begin
                r_q0 <= res;
            end else begin
                r_q0 <= r_q1;
                if (push) begin
                    r_q1 <= res;
                end
            end
        end else if (push) begin
            if (r_q_cnt == 2'd0) begin
                r_q0 <= res;
            end else begin
                r_q1 <= res;
            end
        end
    end

    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, r_q0.value, r_q0.count, r_q0.addr};
    assign o_m_tlast  = r_q0.done;

endmodule
`default_nettype wire

// ===== hw/rtl/rle8_parse.sv =====
`default_nettype none
module rle8_parse (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_start,
    input  wire rle8_pkg::t_geom        i_geom,
    output logic                        o_res_valid,
    output rle8_pkg::t_result           o_res
);
    import rle8_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_DX      = 3'd2,
        PH_DY      = 3'd3,
        PH_LITERAL = 3'd4,
        PH_PAD     = 3'd5
    } t_phase;

    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

    t_phase              r_phase, n_phase, a_phase;
    logic [BYTE_W-1:0]   r_held, n_held, a_held;
    logic [BYTE_W-1:0]   r_dx, n_dx, a_dx;
    logic [BYTE_W-1:0]   r_lit, n_lit, a_lit;
    logic                r_pad, n_pad, a_pad;
    logic [POS_W-1:0]    r_pos, n_pos, a_pos;
    logic [COL_W-1:0]    r_col, n_col, a_col;
    logic                r_fin, n_fin, a_fin;

    function automatic logic [COL_W-1:0] sat_col(input logic [COL_W:0] v);
        sat_col = v[COL_W] ? {COL_W{1'b1}} : v[COL_W-1:0];
    endfunction

    always_comb begin
        logic [POS_W-1:0]   room;
        logic               do_wr;
        logic [COUNT_W-1:0] wr_n;
        logic [BYTE_W-1:0]  wr_val;
        logic               col_clr;
        logic               clip;
        logic [COUNT_W-1:0] cnt;
        logic [20:0]        prod;
        logic [POS_W-1:0]   dpos;
        logic [COL_W:0]     dcol;
        logic [COL_W-1:0]   back;
        logic [BYTE_W-1:0]  lit_dec;

        // start-of-image clears everything before the byte is parsed
        a_phase = i_start ? PH_FIRST : r_phase;
        a_held  = i_start ? '0 : r_held;
        a_dx    = i_start ? '0 : r_dx;
        a_lit   = i_start ? '0 : r_lit;
        a_pad   = i_start ? 1'b0 : r_pad;
        a_pos   = i_start ? '0 : r_pos;
        a_col   = i_start ? '0 : r_col;
        a_fin   = i_start ? 1'b0 : r_fin;

        n_phase = a_phase;
        n_held  = a_held;
        n_dx    = a_dx;
        n_lit   = a_lit;
        n_pad   = a_pad;
        n_pos   = a_pos;
        n_col   = a_col;
        n_fin   = a_fin;

        o_res_valid = 1'b0;
        o_res       = '0;

        room    = i_geom.img_end - a_pos;
        do_wr   = 1'b0;
        wr_n    = '0;
        wr_val  = '0;
        col_clr = 1'b0;
        prod    = 21'(i_geom.stride[COL_W-1:2]) * 21'(i_byte);
        dpos    = a_pos + POS_W'({prod, 2'b00}) + POS_W'(a_dx);
        dcol    = {1'b0, a_col} + (COL_W+1)'(a_dx);
        back    = a_col - i_geom.stride;
        lit_dec = (a_lit != '0) ? a_lit - 8'd1 : a_lit;

        if (!a_fin) begin
            if (a_pos >= i_geom.img_end) begin
                o_res_valid = 1'b1;
                o_res.done  = 1'b1;
                n_fin       = 1'b1;
            end else begin
                case (a_phase)
                    PH_FIRST: begin
                        n_held  = i_byte;
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_phase = PH_FIRST;
                        if (a_held != '0) begin
                            do_wr  = 1'b1;
                            wr_n   = COUNT_W'(a_held);
                            wr_val = i_byte;
                        end else if (i_byte == ESC_EOL) begin
                            n_col = '0;
                            if (a_col < i_geom.stride) begin
                                do_wr   = 1'b1;
                                wr_n    = i_geom.stride - a_col;
                                col_clr = 1'b1;
                            end else if (a_col > i_geom.stride) begin
                                // step back to the row end after an overshoot
                                n_pos = (POS_W'(back) > a_pos) ? '0 : a_pos - POS_W'(back);
                            end
                        end else if (i_byte == ESC_EOB) begin
                            o_res_valid = 1'b1;
                            o_res.done  = 1'b1;
                            n_fin       = 1'b1;
                        end else if (i_byte == ESC_DELTA) begin
                            n_phase = PH_DX;
                        end else begin
                            n_lit   = i_byte;
                            n_pad   = i_byte[0];
                            n_phase = PH_LITERAL;
                        end
                    end
                    PH_DX: begin
                        n_dx    = i_byte;
                        n_phase = PH_DY;
                    end
                    PH_DY: begin
                        n_phase = PH_FIRST;
                        n_pos   = dpos;
                        if (dcol > {1'b0, i_geom.stride}) begin
                            dcol = dcol - {1'b0, i_geom.stride};
                        end
                        n_col = sat_col(dcol);
                        if (dpos >= i_geom.img_end) begin
                            o_res_valid = 1'b1;
                            o_res.done  = 1'b1;
                            n_fin       = 1'b1;
                        end
                    end
                    PH_LITERAL: begin
                        n_lit = lit_dec;
                        if (lit_dec == '0) begin
                            n_phase = a_pad ? PH_PAD : PH_FIRST;
                        end
                        do_wr  = 1'b1;
                        wr_n   = COUNT_W'(1);
                        wr_val = i_byte;
                    end
                    PH_PAD: begin
                        n_phase = PH_FIRST;
                        n_pad   = 1'b0;
                    end
                    default: begin
                        n_phase = PH_FIRST;
                    end
                endcase
            end
        end

        // clipped write at the current position
        clip = (POS_W'(wr_n) >= room);
        cnt  = clip ? room[COUNT_W-1:0] : wr_n;
        if (do_wr) begin
            o_res_valid = 1'b1;
            o_res.addr  = a_pos[ADDR_W-1:0];
            o_res.count = cnt;
            o_res.value = wr_val;
            o_res.done  = clip;
            n_pos       = a_pos + POS_W'(cnt);
            n_col       = col_clr ? '0 : sat_col({1'b0, a_col} + (COL_W+1)'(cnt));
            if (clip) begin
                n_fin = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_held  <= '0;
            r_dx    <= '0;
            r_lit   <= '0;
            r_pad   <= 1'b0;
            r_pos   <= '0;
            r_col   <= '0;
            r_fin   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_dx    <= n_dx;
            r_lit   <= n_lit;
            r_pad   <= n_pad;
            r_pos   <= n_pos;
            r_col   <= n_col;
            r_fin   <= n_fin;
        end
    end

endmodule
`default_nettype wire

// ===== verif/rle8_escape_pkg.sv =====
`timescale 1ns / 1ps
package rle8_escape_pkg;

    // The second byte of a pair, after an escape marker, selects the command
    localparam logic [7:0] ESC_MARK  = 8'h00;
    localparam logic [7:0] ESC_EOL   = 8'h00;
    localparam logic [7:0] ESC_EOB   = 8'h01;
    localparam logic [7:0] ESC_DELTA = 8'h02;

endpackage

// ===== verif/rle8_write_checker.sv =====
`timescale 1ns / 1ps
module rle8_write_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [7:0]                      i_s_tdata,
    input  wire logic                            i_s_tuser,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [rle8_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  wire logic                            i_m_tlast,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [rle8_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rle8_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_end_check,
    output int                                   o_writes_due,
    output int                                   o_mismatches
);
    import rle8_pkg::*;
    import rle8_escape_pkg::*;

    localparam logic [COL_W-1:0] COL_SAT = '1;
    localparam int PRINT_CAP = 50;

    typedef enum logic [2:0] {
        ST_PAIR_LEAD,
        ST_PAIR_CODE,
        ST_DELTA_X,
        ST_DELTA_Y,
        ST_ABS_DATA,
        ST_ABS_PAD
    } t_parse_st;

    logic [WIDTH_W-1:0] cfg_width;
    logic [ROWS_W-1:0]  cfg_rows;

    t_parse_st          st;
    logic [7:0]         pair_lead;
    logic [7:0]         dx_hold;
    logic [7:0]         abs_left;
    logic               pad_due;
    logic [POS_W-1:0]   pos;
    logic [COL_W-1:0]   col;
    logic               img_done;
    logic               end_seen;

    t_result            pending_writes [$];

    initial begin
        o_writes_due = 0;
        o_mismatches = 0;
        end_seen     = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= PRINT_CAP)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [WIDTH_W-1:0] row_stride();
        logic [WIDTH_W-1:0] w;
        w = (cfg_width == '0) ? WIDTH_W'(1) : cfg_width;
        if (w > MAX_ROW_BYTES)
            w = WIDTH_W'(MAX_ROW_BYTES);
        return (w + WIDTH_W'(3)) & ~WIDTH_W'(3);
    endfunction

    function automatic logic [POS_W-1:0] image_limit();
        logic [POS_W-1:0] r;
        r = (cfg_rows == '0) ? POS_W'(1) : POS_W'(cfg_rows);
        if (r > MAX_ROWS)
            r = POS_W'(MAX_ROWS);
        return POS_W'(row_stride()) * r;
    endfunction

    function automatic logic [COL_W-1:0] col_sat(input logic [23:0] c);
        return (c > 24'(COL_SAT)) ? COL_SAT : c[COL_W-1:0];
    endfunction

    function automatic void restart_image();
        st        = ST_PAIR_LEAD;
        pair_lead = '0;
        dx_hold   = '0;
        abs_left  = '0;
        pad_due   = 1'b0;
        pos       = '0;
        col       = '0;
        img_done  = 1'b0;
    endfunction

    function automatic void queue_done();
        t_result r;
        r.addr  = '0;
        r.count = '0;
        r.value = '0;
        r.done  = 1'b1;
        pending_writes.push_back(r);
        img_done = 1'b1;
    endfunction

    // Clip the write at the image end; the clipped write closes the image
    function automatic void queue_write(input logic [POS_W-1:0] n_req, input logic [7:0] val);
        logic [POS_W-1:0] room;
        logic [POS_W-1:0] n;
        t_result r;
        room   = image_limit() - pos;
        n      = n_req;
        r.done = 1'b0;
        if (n >= room) begin
            n      = room;
            r.done = 1'b1;
        end
        r.addr  = pos[ADDR_W-1:0];
        r.count = n[COUNT_W-1:0];
        r.value = val;
        pending_writes.push_back(r);
        pos = pos + n;
        col = col_sat(24'(col) + 24'(n));
        if (r.done)
            img_done = 1'b1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic first);
        logic [WIDTH_W-1:0] stride;
        logic [23:0]        c;
        logic [COL_W-1:0]   back;
        if (first)
            restart_image();
        stride = row_stride();
        if (img_done)
            return;
        if (pos >= image_limit()) begin
            queue_done();
            return;
        end
        case (st)
            ST_PAIR_LEAD: begin
                pair_lead = b;
                st        = ST_PAIR_CODE;
            end
            ST_PAIR_CODE: begin
                st = ST_PAIR_LEAD;
                if (pair_lead != ESC_MARK) begin
                    queue_write(POS_W'(pair_lead), b);
                end else if (b == ESC_EOL) begin
                    if (col < stride) begin
                        queue_write(POS_W'(stride - col), 8'h00);
                    end else if (col > stride) begin
                        // overshot the row: step back to the row end, not below zero
                        back = col - stride;
                        pos  = (POS_W'(back) > pos) ? '0 : pos - POS_W'(back);
                    end
                    col = '0;
                end else if (b == ESC_EOB) begin
                    queue_done();
                end else if (b == ESC_DELTA) begin
                    st = ST_DELTA_X;
                end else begin
                    abs_left = b;
                    pad_due  = b[0];
                    st       = ST_ABS_DATA;
                end
            end
            ST_DELTA_X: begin
                dx_hold = b;
                st      = ST_DELTA_Y;
            end
            ST_DELTA_Y: begin
                st  = ST_PAIR_LEAD;
                c   = 24'(col) + 24'(dx_hold);
                pos = pos + POS_W'(stride) * POS_W'(b) + POS_W'(dx_hold);
                // wrap the column once only
                if (c > 24'(stride))
                    c = c - 24'(stride);
                col = col_sat(c);
                if (pos >= image_limit())
                    queue_done();
            end
            ST_ABS_DATA: begin
                if (abs_left > 0)
                    abs_left--;
                if (abs_left == 0)
                    st = pad_due ? ST_ABS_PAD : ST_PAIR_LEAD;
                queue_write(POS_W'(1), b);
            end
            ST_ABS_PAD: begin
                st      = ST_PAIR_LEAD;
                pad_due = 1'b0;
            end
            default: st = ST_PAIR_LEAD;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_width = WIDTH_W'(1);
            cfg_rows  = ROWS_W'(1);
            restart_image();
            pending_writes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.addr  = i_m_tdata[ADDR_W-1:0];
                got.count = i_m_tdata[ADDR_W +: COUNT_W];
                got.value = i_m_tdata[ADDR_W+COUNT_W +: BYTE_W];
                got.done  = i_m_tlast;
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat addr %0d count %0d value %0h done %0b",
                                              got.addr, got.count, got.value, got.done));
                end else begin
                    want = pending_writes.pop_front();
                    if (got.addr !== want.addr)
                        report_mismatch($sformatf("write_addr got %0d want %0d",
                                                  got.addr, want.addr));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("fill_count got %0d want %0d at addr %0d",
                                                  got.count, want.count, want.addr));
                    if (got.value !== want.value)
                        report_mismatch($sformatf("fill_value got %0h want %0h at addr %0d",
                                                  got.value, want.value, want.addr));
                    if (got.done !== want.done)
                        report_mismatch($sformatf("image_done got %0b want %0b at addr %0d",
                                                  got.done, want.done, want.addr));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WIDTH_PIXELS)
                    cfg_width = i_cfg_data[WIDTH_W-1:0];
                else if (i_cfg_index == REG_ROW_COUNT)
                    cfg_rows = i_cfg_data[ROWS_W-1:0];
            end
            if (i_s_tvalid && i_s_tready)
                decode_byte(i_s_tdata, i_s_tuser);
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (pending_writes.size() != 0)
                    report_mismatch($sformatf("%0d write commands never arrived",
                                              pending_writes.size()));
            end
        end
        o_writes_due <= pending_writes.size();
    end

endmodule

// ===== verif/bmp_rle8_decoder_tb.sv =====
`timescale 1ns / 1ps
module bmp_rle8_decoder_tb;
    import rle8_pkg::*;
    import rle8_escape_pkg::*;

    localparam int RUN_LIMIT_NS   = 2_000_000;
    localparam int LATENCY_CYCLES = 4;
    localparam int RANDOM_ITEMS   = 700;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 300;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [7:0]              i_s_tdata;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    o_m_tlast;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    end_check;

    int writes_due;
    int mismatches;

    int burst_left    = 0;
    bit gaps_on       = 1'b1;
    bit next_start    = 1'b0;
    int sent_bytes    = 0;
    int hold_requests = 0;

    always #5 i_clk = ~i_clk;

    bmp_rle8_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rle8_write_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_end_check  (end_check),
        .o_writes_due (writes_due),
        .o_mismatches (mismatches)
    );

    // Offer one byte, with a random gap between bursts when gaps are enabled
    task automatic push_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= next_start;
        next_start = 1'b0;
        do @(posedge i_clk); while (!o_s_tready);
        sent_bytes++;
    endtask

    // Stop sending, wait for every write command, then let the pipeline drain
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (writes_due != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] r);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_WIDTH_PIXELS;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int hold_served;
        int hold_left;
        int mode;
        int mode_left;
        int cyc;
        hold_served = 0;
        hold_left   = 0;
        mode        = 0;
        mode_left   = 0;
        cyc         = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    2: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= (cyc % 8) < 3;
                endcase
            end
        end
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] script [$];
        int phase;
        int phase_start;
        int elems_left;
        int kind;
        int n;
        int w;
        int r;
        bit tiny;
        bit allow_eob;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WIDTH_PIXELS;
        i_cfg_data  = '0;
        end_check   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stride 12, end 36: run, odd absolute block with pad, overshoot and step back,
        // wrapping delta, clipped end-of-line fill, ignored bytes, then end of bitmap
        set_geometry(CFG_DATA_W'(10), CFG_DATA_W'(3));
        script = '{8'h04, 8'h5A,
                   ESC_MARK, 8'h03, 8'h01, 8'h80, 8'hFF, 8'h00,
                   8'h0D, 8'h33,
                   ESC_MARK, ESC_EOL,
                   ESC_MARK, ESC_DELTA, 8'h0E, 8'h00,
                   ESC_MARK, ESC_EOL,
                   ESC_MARK, ESC_EOB,
                   ESC_MARK, ESC_EOB};
        foreach (script[i]) begin
            if (i == 0 || i == 20)
                next_start = 1'b1;
            push_byte(script[i]);
        end
        settle();

        for (phase = 0; sent_bytes < RANDOM_ITEMS; phase++) begin
            case (phase % 7)
                0: begin w = 4096; r = 1024; end
                1: begin w = 1;    r = 1;    end
                2: begin w = 0;    r = 0;    end
                3: begin w = 8191; r = 2047; end
                5: begin w = $urandom_range(1, 300); r = $urandom_range(1, 40); end
                default: begin w = $urandom_range(1, 40); r = $urandom_range(1, 6); end
            endcase
            set_geometry(CFG_DATA_W'(w), CFG_DATA_W'(r));
            tiny    = (w <= 16 && r <= 4);
            gaps_on = (phase % 3) != 2;
            if (phase == 0)
                hold_requests++;
            // after the large image, keep going without a restart so the position
            // already lies past the new image end
            next_start = (phase % 7 == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            elems_left = tiny ? $urandom_range(1, 3) : $urandom_range(4, 30);
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_ITEMS) begin
                if (elems_left == 0) begin
                    next_start = 1'b1;
                    elems_left = tiny ? $urandom_range(1, 3) : $urandom_range(4, 30);
                end
                // leave the last image open so the next phase can pick it up
                allow_eob = (sent_bytes - phase_start) < PHASE_ITEMS - 25;
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                    : $urandom_range(1, 12);
                    push_byte(8'(n));
                    push_byte(8'($urandom_range(0, 255)));
                end else if (kind < 60) begin
                    n = ($urandom_range(0, 29) == 0) ? $urandom_range(3, 255)
                                                     : $urandom_range(3, 12);
                    push_byte(ESC_MARK);
                    push_byte(8'(n));
                    repeat (n) push_byte(8'($urandom_range(0, 255)));
                    if (n % 2 == 1)
                        push_byte(8'($urandom_range(0, 255)));
                end else if (kind < 72) begin
                    push_byte(ESC_MARK);
                    push_byte(ESC_EOL);
                end else if (kind < 84) begin
                    push_byte(ESC_MARK);
                    push_byte(ESC_DELTA);
                    push_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 15)));
                    push_byte(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 2)));
                end else if (kind < 88 && allow_eob) begin
                    push_byte(ESC_MARK);
                    push_byte(ESC_EOB);
                    elems_left = 1;
                end else begin
                    // stray byte, throws the pair alignment off
                    push_byte(8'($urandom_range(0, 255)));
                end
                elems_left--;
            end
            settle();
        end

        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
